@@ design/smde_pkg.sv @@
// ----------------------------------------------------------------------------
// smde_pkg - shared types and constants for the switch matrix debouncer
// Operation and register codes, the per-column store entry and the event job.
// ----------------------------------------------------------------------------
package smde_pkg;

    localparam int ROW_W          = 3;
    localparam int ROWS           = 8;
    localparam int COL_W          = 4;
    localparam int IDX_W          = 7;
    localparam int MASK_BYTES     = 10;
    localparam int MASK_LOW_W     = 64;
    localparam int MASK_HIGH_W    = 16;
    localparam int MASK_W         = MASK_LOW_W + MASK_HIGH_W;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 2;
    localparam int IN_TDATA_W     = 24;
    localparam int OUT_TDATA_W    = 8;

    // Operation codes
    localparam logic [1:0] OP_SCAN    = 2'd0;
    localparam logic [1:0] OP_SERVICE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OPTO_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OPTO_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_LOW  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_HIGH = 2'd3;

    // One column of debounce state
    typedef struct packed {
        logic [ROWS-1:0] pending;
        logic [ROWS-1:0] changed;
        logic [ROWS-1:0] raw;
    } entry_t;

    // Events still to be sent for one item: one per set bit of hits
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROWS-1:0]  hits;
        logic             level;
    } job_t;

endpackage

@@ design/switch_matrix_debounce_events.sv @@
// ----------------------------------------------------------------------------
// switch_matrix_debounce_events - switch matrix debouncer and event reporter
// Scan, service and query items against per-column debounce state.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata. A scan transfer stores a
//   column's raw byte and updates its changed and pending bytes; a service
//   transfer sends one event per qualified pending row of a column (lowest
//   row first, m_tlast on the final one) and clears pending; a query sends
//   one result with the switch's logical level, level 0 for a switch number
//   past the matrix. Scans, scans and services of a column past the matrix
//   and the unused operation send nothing.
//   A result passes the read stage, the job register and the output register.
//   Throughput: one item per cycle while the event sequencer keeps up; an
//   item that sends n events holds the sequencer until all n are sent, so the
//   rate is set by the sequencer's one event per cycle while m_tready is high.
//   The column state lives in a one-port-write, one-port-read memory with a
//   registered read; each item reads at acceptance and writes back as it
//   leaves the read stage, at the earliest in the next cycle, and a write on the
//   read edge is bypassed to the reader.
//   Reset clears the masks, the valid bits of the state memory (so every
//   column reads as zero) and all handshake state; no clearing pass is run.
//   When m_tready is low the result holds in the output register, the next job
//   waits in the sequencer and one more item waits in the read stage before
//   s_tready drops. Write configuration only while idle; the block does not check.
// ----------------------------------------------------------------------------
module switch_matrix_debounce_events
    import smde_pkg::*;
#(
    parameter int COLUMNS = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // operation[1:0], column[5:2], raw_bits[13:6], switch_index[20:14], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // switch_number[6:0], level[7]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Configuration registers
    logic [MASK_LOW_W-1:0]  opto_low_reg;
    logic [MASK_HIGH_W-1:0] opto_high_reg;
    logic [MASK_LOW_W-1:0]  edge_low_reg;
    logic [MASK_HIGH_W-1:0] edge_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opto_low_reg  <= '0;
            opto_high_reg <= '0;
            edge_low_reg  <= '0;
            edge_high_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_OPTO_LOW:  opto_low_reg  <= cfg_data;
                REG_OPTO_HIGH: opto_high_reg <= cfg_data[MASK_HIGH_W-1:0];
                REG_EDGE_LOW:  edge_low_reg  <= cfg_data;
                REG_EDGE_HIGH: edge_high_reg <= cfg_data[MASK_HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    // Input field unpacking
    logic [1:0]       in_op;
    logic [COL_W-1:0] in_col;
    logic [ROWS-1:0]  in_raw;
    logic [IDX_W-1:0] in_idx;
    logic [COL_W-1:0] in_addr;
    logic             in_range;
    logic             in_fire;

    assign in_op    = s_tdata[1:0];
    assign in_col   = s_tdata[5:2];
    assign in_raw   = s_tdata[13:6];
    assign in_idx   = s_tdata[20:14];

    // A query addresses the column that holds its switch
    assign in_addr  = (in_op == OP_QUERY) ? in_idx[IDX_W-1:ROW_W] : in_col;
    assign in_range = (int'(in_addr) < COLUMNS);
    assign in_fire  = s_tvalid && s_tready;

    // Read stage: item waits here for its memory word
    logic             s1_valid_reg;
    logic [1:0]       s1_op_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROWS-1:0]  s1_raw_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_range_reg;
    logic             s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= in_op;
            s1_col_reg   <= in_addr;
            s1_raw_reg   <= in_raw;
            s1_row_reg   <= in_idx[ROW_W-1:0];
            s1_range_reg <= in_range;
        end
    end

    // State memory
    entry_t  cur;
    entry_t  wr_data;
    logic    wr_en;

    smde_store #(
        .COLUMNS (COLUMNS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire && in_range),
        .rd_addr (in_addr[AW-1:0]),
        .rd_data (cur),
        .wr_en   (wr_en),
        .wr_addr (s1_col_reg[AW-1:0]),
        .wr_data (wr_data)
    );

    // Mask bytes of the column in the read stage
    logic [MASK_W-1:0] opto_all;
    logic [MASK_W-1:0] edge_all;
    logic [ROWS-1:0]   opto_byte;
    logic [ROWS-1:0]   edge_byte;

    assign opto_all = {opto_high_reg, opto_low_reg};
    assign edge_all = {edge_high_reg, edge_low_reg};

    always_comb
    begin
        opto_byte = '0;
        edge_byte = '0;
        for (int i = 0; i < MASK_BYTES; i++)
        begin
            if (s1_col_reg == COL_W'(i))
            begin
                opto_byte = opto_all[i*ROWS +: ROWS];
                edge_byte = edge_all[i*ROWS +: ROWS];
            end
        end
    end

    // Modify: debounce update, service qualification and query level
    logic [ROWS-1:0] logical;
    logic [ROWS-1:0] hits;
    logic [ROWS-1:0] chg;
    logic            is_scan;
    logic            is_service;
    logic            is_query;
    logic            has_result;
    logic            job_free;
    job_t            job;

    assign logical    = cur.raw ^ opto_byte;
    assign hits       = cur.pending & (logical | edge_byte);
    assign chg        = cur.raw ^ s1_raw_reg;
    assign is_scan    = (s1_op_reg == OP_SCAN);
    assign is_service = (s1_op_reg == OP_SERVICE);
    assign is_query   = (s1_op_reg == OP_QUERY);

    always_comb
    begin
        if (is_scan)
        begin
            wr_data.raw     = s1_raw_reg;
            wr_data.changed = chg;
            // Promote rows that changed last scan and held still this one
            wr_data.pending = cur.pending | (cur.changed & ~chg);
        end
        else
        begin
            wr_data.raw     = cur.raw;
            wr_data.changed = cur.changed;
            wr_data.pending = '0;
        end
    end

    always_comb
    begin
        job.col = s1_col_reg;
        if (is_query)
        begin
            // One event whose row is the queried row
            job.hits  = ROWS'(1) << s1_row_reg;
            job.level = s1_range_reg && logical[s1_row_reg];
        end
        else
        begin
            job.hits  = hits;
            job.level = 1'b1;
        end
    end

    assign has_result = is_query || (is_service && s1_range_reg && (hits != '0));
    assign s1_advance = s1_valid_reg && (!has_result || job_free);
    assign wr_en      = s1_advance && s1_range_reg && (is_scan || is_service);
    assign s_tready   = !s1_valid_reg || s1_advance;

    smde_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_advance && has_result),
        .job      (job),
        .job_free (job_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_op_reg)
                                           && $stable(s1_col_reg)))
        else $error("stalled item lost from read stage");

    a_no_write_on_query : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (s1_valid_reg && !is_query))
        else $error("state written without a scan or service");

endmodule

@@ design/smde_store.sv @@
// ----------------------------------------------------------------------------
// smde_store - column state memory
// One entry per column, registered read, per-entry valid bits so that an
// entry never written reads as zero, and a bypass for a write on the same edge.
// ----------------------------------------------------------------------------
module smde_store
    import smde_pkg::*;
#(
    parameter int  COLUMNS = 10,
    localparam int AW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t               mem [COLUMNS];
    entry_t               rd_q_reg;
    entry_t               byp_data_reg;
    logic                 byp_reg;
    logic                 vld_q_reg;
    logic [COLUMNS-1:0]   vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_q_reg <= vld_reg[rd_addr];
                byp_reg   <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // Take the write of the read edge over the stale array data
    assign rd_data = byp_reg ? byp_data_reg : (vld_q_reg ? rd_q_reg : '0);

    a_wr_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (int'(wr_addr) < COLUMNS))
        else $error("store write beyond last column");

endmodule

@@ design/smde_emit.sv @@
// ----------------------------------------------------------------------------
// smde_emit - event sequencer and output register
// Hold one job and send one event per set bit, lowest row first.
// ----------------------------------------------------------------------------
module smde_emit
    import smde_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  job_t                   job,
    output logic                   job_free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    job_t                 job_reg;
    logic                 job_valid_reg;
    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_num_reg;
    logic                 out_level_reg;
    logic                 out_last_reg;

    logic [ROW_W-1:0]     row;
    logic [ROWS-1:0]      rest;
    logic                 out_free;
    logic                 emit_fire;
    logic                 emit_last;

    always_comb
    begin
        row = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (job_reg.hits[i])
            begin
                row = ROW_W'(i);
            end
        end
    end

    assign rest      = job_reg.hits & (job_reg.hits - ROWS'(1));
    assign out_free  = !out_valid_reg || m_tready;
    assign emit_fire = job_valid_reg && out_free;
    assign emit_last = (rest == '0);
    assign job_free  = !job_valid_reg || (emit_fire && emit_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                job_valid_reg <= 1'b1;
            end
            else if (emit_fire && emit_last)
            begin
                job_valid_reg <= 1'b0;
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
        end
        else if (emit_fire)
        begin
            job_reg.hits <= rest;
        end
        if (emit_fire)
        begin
            out_num_reg   <= {job_reg.col, row};
            out_level_reg <= job_reg.level;
            out_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_level_reg, out_num_reg};
    assign m_tlast  = out_last_reg;

    a_load_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        load |-> job_free)
        else $error("job loaded over one still sending");

    a_job_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_reg.hits != '0))
        else $error("active job has no events left");

endmodule
